// ----- hw/rtl/rbnh_pkg.sv -----
// ----------------------------------------------------------------------------
// rbnh_pkg: shared constants for the ray / box nearest hit block
// Default fixed-point format, axis count and register map.
// ----------------------------------------------------------------------------
package rbnh_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 6;

  // Register map, one register per slot
  localparam int REG_ORIGIN_X    = 0;
  localparam int REG_DIRECTION_X = 3;

endpackage

// ----- hw/rtl/ray_box_nearest_hit_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_top: nearest ray / axis-aligned box hit
// Tests streamed boxes against one configured ray and keeps the nearest hit.
//
// Usage:
//   Write the ray origin and direction over the APB port while the block is
//   idle (registers at byte addresses 0, 4, .. 20 for the default format).
//   Send boxes on the s_ channel; each box gives exactly one result on the
//   m_ channel: the hit flag plus the kept nearest t and hit point.
//   A box is taken only when the sequencer is idle. An origin inside a valid
//   box goes straight from the check to the result. Otherwise the six slab
//   quotients run one after another through a single restoring divider,
//   which sets the throughput. A zero direction component skips the
//   divisions for its axis.
//   The result sits in an output register; a new box is accepted while it
//   waits, but the next result is held back until the receiver takes it.
//   Reset clears the registers to zero, the nearest t to the largest
//   positive value and the hit point to zero.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_top #(
  parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbnh_pkg::FRAC_BITS_DEF,
  localparam int DATA_WIDTH = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_WIDTH = $clog2(rbnh_pkg::NUM_REGS * (DATA_WIDTH / 8)),
  localparam int IN_WIDTH   = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_WIDTH  = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  // box requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [IN_WIDTH-1:0]   s_tdata,
  // box_valid, restart
  input  logic [1:0]            s_tuser,
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // nearest_distance, hit_point_x, hit_point_y, hit_point_z
  output logic [OUT_WIDTH-1:0]  m_tdata,
  // hit
  output logic [0:0]            m_tuser
);
  import rbnh_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam logic signed [CW-1:0]   VMAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]   VMIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [2*CW:0]   VMAX_W = {{(CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [2*CW:0]   VMIN_W = {{(CW+2){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [2*CW-1:0]        RND_MASK = ~({(2*CW){1'b1}} << FRAC_BITS);
  localparam logic [1:0]             LAST_AXIS = 2'(NUM_AXES - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SETUP  = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_ADD    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [CW-1:0]   origin    [NUM_AXES];
  logic signed [CW-1:0]   direction [NUM_AXES];
  logic signed [CW-1:0]   lo        [NUM_AXES];
  logic signed [CW-1:0]   hi        [NUM_AXES];
  logic                   box_ok;
  logic signed [CW-1:0]   best_distance;
  logic signed [CW-1:0]   best_point [NUM_AXES];
  logic signed [CW-1:0]   max_in;
  logic signed [CW-1:0]   min_out;
  logic                   reject;
  logic                   hit;
  logic [1:0]             axis;
  logic                   half;
  logic signed [2*CW-1:0] prod;

  logic                   origin_in;
  logic signed [CW-1:0]   o_sel;
  logic signed [CW-1:0]   d_sel;
  logic signed [CW-1:0]   lo_sel;
  logic signed [CW-1:0]   hi_sel;
  logic                   d_zero;
  logic                   d_pos;
  logic                   slab_out;
  logic signed [CW-1:0]   bound;
  logic signed [CW:0]     num;
  logic                   div_start;
  logic                   div_done;
  logic signed [CW-1:0]   quot;
  logic signed [2*CW-1:0] prod_adj;
  logic signed [2*CW-1:0] prod_sh;
  logic signed [2*CW:0]   point_sum;
  logic signed [CW-1:0]   point_sat;
  logic                   new_hit;

  rbnh_cfg #(
    .COORD_WIDTH(COORD_WIDTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .origin   (origin),
    .direction(direction)
  );

  assign pready = 1'b1;

  rbnh_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (d_sel),
    .done (div_done),
    .quot (quot)
  );

  // Origin inside the whole box
  always_comb begin
    origin_in = box_ok;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (origin[a] < lo[a] || origin[a] > hi[a]) begin
        origin_in = 1'b0;
      end
    end
  end

  // Select the current axis and form the slab numerator
  assign o_sel    = origin[axis];
  assign d_sel    = direction[axis];
  assign lo_sel   = lo[axis];
  assign hi_sel   = hi[axis];
  assign d_zero   = d_sel == '0;
  assign d_pos    = !d_sel[CW-1] && !d_zero;
  assign slab_out = (o_sel < lo_sel) || (o_sel > hi_sel);
  assign bound    = (half == d_pos) ? hi_sel : lo_sel;
  assign num      = {bound[CW-1], bound} - {o_sel[CW-1], o_sel};
  assign div_start = (state == S_DIV) ? 1'b0 : ((state == S_SETUP) && !d_zero);

  // Hit acceptance test
  assign new_hit = !reject && !max_in[CW-1] && (max_in <= min_out) &&
                   (max_in < best_distance);

  // Scale the product back, truncating toward zero, then add and clamp
  assign prod_adj  = prod + (prod[2*CW-1] ? signed'(RND_MASK) : '0);
  assign prod_sh   = prod_adj >>> FRAC_BITS;
  assign point_sum = {{(CW+1){o_sel[CW-1]}}, o_sel} + {prod_sh[2*CW-1], prod_sh};
  always_comb begin
    if (point_sum > VMAX_W) begin
      point_sat = VMAX;
    end else if (point_sum < VMIN_W) begin
      point_sat = VMIN;
    end else begin
      point_sat = point_sum[CW-1:0];
    end
  end

  assign s_tready = state == S_IDLE;

  // Sequencer and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      best_distance <= VMAX;
      for (int a = 0; a < NUM_AXES; a++) begin
        best_point[a] <= '0;
      end
    end else begin
      // Drop a taken result unless a finished box refills the register
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              lo[a] <= s_tdata[a*CW +: CW];
              hi[a] <= s_tdata[(a+NUM_AXES)*CW +: CW];
            end
            box_ok <= s_tuser[0];
            if (s_tuser[1]) begin
              best_distance <= VMAX;
            end
            hit   <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (origin_in) begin
            best_distance <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
              best_point[a] <= origin[a];
            end
            hit   <= 1'b1;
            state <= S_DONE;
          end else begin
            max_in  <= VMIN;
            min_out <= VMAX;
            reject  <= 1'b0;
            axis    <= '0;
            half    <= 1'b0;
            state   <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (d_zero) begin
            // Ray parallel to this slab: reject when the origin is outside
            if (slab_out) begin
              reject <= 1'b1;
            end
            if (axis == LAST_AXIS) begin
              state <= S_DECIDE;
            end else begin
              axis <= axis + 1'b1;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!half) begin
              if (quot > max_in) begin
                max_in <= quot;
              end
              half  <= 1'b1;
              state <= S_SETUP;
            end else begin
              if (quot < min_out) begin
                min_out <= quot;
              end
              half <= 1'b0;
              if (axis == LAST_AXIS) begin
                state <= S_DECIDE;
              end else begin
                axis  <= axis + 1'b1;
                state <= S_SETUP;
              end
            end
          end
        end
        S_DECIDE: begin
          axis <= '0;
          if (new_hit) begin
            best_distance <= max_in;
            hit           <= 1'b1;
            state         <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          prod  <= d_sel * max_in;
          state <= S_ADD;
        end
        S_ADD: begin
          best_point[axis] <= point_sat;
          if (axis == LAST_AXIS) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_WIDTH'({best_point[2], best_point[1], best_point[0],
                                    best_distance});
            m_tuser  <= hit;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/rbnh_cfg.sv -----
// ----------------------------------------------------------------------------
// rbnh_cfg: configuration register file
// APB-style write and read of the ray origin and direction registers.
// ----------------------------------------------------------------------------
module rbnh_cfg #(
  parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH_DEF,
  parameter int DATA_WIDTH  = 32,
  parameter int ADDR_WIDTH  = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic signed [COORD_WIDTH-1:0] origin    [rbnh_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] direction [rbnh_pkg::NUM_AXES]
);
  import rbnh_pkg::*;

  localparam int ALIGN_BITS = (DATA_WIDTH > 32) ? 3 : 2;
  localparam int IDX_WIDTH  = ADDR_WIDTH - ALIGN_BITS;

  logic [COORD_WIDTH-1:0] regs [NUM_REGS];
  logic [IDX_WIDTH-1:0]   idx;
  logic                   idx_ok;

  assign idx    = paddr[ADDR_WIDTH-1:ALIGN_BITS];
  assign idx_ok = idx < IDX_WIDTH'(NUM_REGS);

  // Write on the access phase of a request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (psel && penable && pwrite && idx_ok) begin
      regs[idx] <= pwdata[COORD_WIDTH-1:0];
    end
  end

  // Read back the addressed register, zero beyond the map
  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = DATA_WIDTH'(regs[idx]);
    end
  end

  // Present the ray to the datapath
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      origin[a]    = signed'(regs[REG_ORIGIN_X + a]);
      direction[a] = signed'(regs[REG_DIRECTION_X + a]);
    end
  end

endmodule

// ----- hw/rtl/rbnh_div.sv -----
// ----------------------------------------------------------------------------
// rbnh_div: shared slab divider
// Radix-2 restoring division of (num * 2^FRAC_BITS) by den, truncated
// toward zero and saturated to the coordinate range. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module rbnh_div #(
  parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbnh_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH:0]   num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] quot
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = (CW + 1 + FRAC_BITS > 2 * CW) ? CW + 1 + FRAC_BITS : 2 * CW;
  localparam int CNTW = $clog2(CW + 1);
  localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

  logic [RW-1:0]   rem;
  logic [RW-1:0]   dsh;
  logic [CW:0]     qm;
  logic            neg;
  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [CW:0]     num_mag;
  logic [CW-1:0]   den_mag;
  logic            ge;

  assign num_mag = num[CW] ? unsigned'(-num) : unsigned'(num);
  assign den_mag = den[CW-1] ? unsigned'(-den) : unsigned'(den);
  assign ge      = rem >= dsh;

  // Load operands, then produce quotient bits from bit CW down to bit 0
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(CW);
        rem  <= RW'(num_mag) << FRAC_BITS;
        dsh  <= RW'(den_mag) << CW;
        qm   <= '0;
        neg  <= num[CW] ^ den[CW-1];
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        qm  <= {qm[CW-1:0], ge};
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Apply the sign and clamp; a set top bit means the magnitude overflowed
  always_comb begin
    if (neg) begin
      if (qm[CW] || (qm[CW-1] && (|qm[CW-2:0]))) begin
        quot = VMIN;
      end else begin
        quot = -signed'(qm[CW-1:0]);
      end
    end else begin
      if (qm[CW] || qm[CW-1]) begin
        quot = VMAX;
      end else begin
        quot = signed'(qm[CW-1:0]);
      end
    end
  end

endmodule

// ----- tb/sv/ray_box_nearest_hit_top_tb.sv -----
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_top_tb: self-checking bench for the nearest hit block
// Sets a ray over APB, streams axis-aligned box requests and checks every
// result against an in-bench nearest hit tracker, typed directed rows
// against their table values. A short directed table comes first, then
// random boxes for several rays, random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = rbnh_pkg::COORD_WIDTH_DEF;
  localparam int FB     = rbnh_pkg::FRAC_BITS_DEF;
  localparam int AXES   = rbnh_pkg::NUM_AXES;
  localparam int DW     = (CW > 32) ? 64 : 32;
  localparam int AW     = $clog2(rbnh_pkg::NUM_REGS * (DW / 8));
  localparam int IW     = ((6 * CW + 7) / 8) * 8;
  localparam int OW     = ((4 * CW + 7) / 8) * 8;
  localparam int ONE    = 1 << FB;

  localparam int N_DIRECTED  = 16;
  localparam int N_PHASES    = 19;
  localparam int PHASE_BOXES = 100;
  localparam int DRAIN       = 300;
  localparam int CYCLE_LIMIT = 2_500_000;

  localparam longint VMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef logic [CW-1:0]          coord_t;
  typedef logic [AXES-1:0][CW-1:0] vec3_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic  restart;
    logic  box_valid;
    vec3_t hi;
    vec3_t lo;
  } box_t;

  typedef struct packed {
    logic   hit;
    vec3_t  point;
    coord_t distance;
  } result_t;

  typedef struct packed {
    box_t    box;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic          pready;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  logic [IW-1:0] s_tdata = '0;
  // box_valid, restart
  logic [1:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  // nearest_distance, hit_point_x, hit_point_y, hit_point_z
  logic [OW-1:0] m_tdata;
  // hit
  logic [0:0]    m_tuser;

  // Ray as last written, and the kept nearest hit
  vec3_t   ray_org = '0;
  vec3_t   ray_dir = '0;
  longint  best_t = VMAX;
  longint  best_pt [AXES] = '{0, 0, 0};

  result_t  hits_due [$];
  dir_row_t dir_tab [N_DIRECTED];
  int       errors = 0;
  int       results_seen = 0;
  int       send_burst = 0;
  int       recv_burst = 0;
  int       cycles = 0;

  ray_box_nearest_hit_top u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic longint clamp(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic coord_t to_coord(longint v);
    longint c;
    c = clamp(v);
    return c[CW-1:0];
  endfunction

  // Exact quotient, truncated toward zero, then saturated
  function automatic longint slab_quot(longint num, longint den);
    longint scaled;
    scaled = num * (longint'(1) << FB);
    return clamp(scaled / den);
  endfunction

  // Full product scaled down, truncating toward zero
  function automatic longint scale_t(longint d, longint t);
    longint p;
    p = d * t;
    if (p < 0) return -((-p) >> FB);
    return p >> FB;
  endfunction

  // --------------------------------------------------------------------------
  // Nearest hit tracker: advance the kept state by one box
  // --------------------------------------------------------------------------
  function automatic result_t track_nearest_hit(box_t b);
    longint  o [AXES];
    longint  d [AXES];
    longint  lo [AXES];
    longint  hi [AXES];
    longint  ent, ext, max_in, min_out;
    logic    origin_in, reject, hit;
    result_t r;
    int      a;
    for (a = 0; a < AXES; a++) begin
      o[a]  = longint'($signed(ray_org[a]));
      d[a]  = longint'($signed(ray_dir[a]));
      lo[a] = longint'($signed(b.lo[a]));
      hi[a] = longint'($signed(b.hi[a]));
    end
    if (b.restart) best_t = VMAX;
    origin_in = b.box_valid;
    for (a = 0; a < AXES; a++)
      if (o[a] < lo[a] || o[a] > hi[a]) origin_in = 1'b0;
    hit = 1'b0;
    reject = 1'b0;
    if (origin_in) begin
      // origin inside: t = 0 wins regardless of the kept distance
      best_t = 0;
      for (a = 0; a < AXES; a++) best_pt[a] = o[a];
      hit = 1'b1;
    end else begin
      max_in = VMIN;
      min_out = VMAX;
      for (a = 0; a < AXES; a++) begin
        if (d[a] > 0) begin
          ent = slab_quot(lo[a] - o[a], d[a]);
          ext = slab_quot(hi[a] - o[a], d[a]);
        end else if (d[a] < 0) begin
          ent = slab_quot(hi[a] - o[a], d[a]);
          ext = slab_quot(lo[a] - o[a], d[a]);
        end else begin
          if (o[a] < lo[a] || o[a] > hi[a]) reject = 1'b1;
          ent = VMIN;
          ext = VMAX;
        end
        if (ent > max_in) max_in = ent;
        if (ext < min_out) min_out = ext;
      end
      if (!reject && max_in >= 0 && max_in <= min_out && max_in < best_t) begin
        best_t = max_in;
        for (a = 0; a < AXES; a++) best_pt[a] = clamp(o[a] + scale_t(d[a], max_in));
        hit = 1'b1;
      end
    end
    r.hit      = hit;
    r.distance = best_t[CW-1:0];
    for (a = 0; a < AXES; a++) r.point[a] = best_pt[a][CW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic dir_row_t dir_row(coord_t lx, coord_t ly, coord_t lz,
                                       coord_t hx, coord_t hy, coord_t hz,
                                       logic valid, logic restart, logic typed,
                                       logic w_hit, coord_t w_dist);
    dir_row_t t;
    t.box.lo        = {lz, ly, lx};
    t.box.hi        = {hz, hy, hx};
    t.box.box_valid = valid;
    t.box.restart   = restart;
    t.typed         = typed;
    t.want.hit      = w_hit;
    t.want.distance = w_dist;
    t.want.point    = '0;
    return t;
  endfunction

  // Idle cycles before the next request, with occasional back-to-back runs
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(5, 30);
    return $urandom_range(0, 16);
  endfunction

  function automatic coord_t rand_coord(int span);
    longint v;
    v = longint'($urandom_range(0, 2 * span * ONE)) - longint'(span) * ONE;
    return to_coord(v);
  endfunction

  // Mostly boxes straddling the ray, some around the origin, some turned
  // inside out, and a share of raw noise
  function automatic box_t make_box();
    box_t   b;
    longint o, d, c, t, m_lo, m_hi;
    coord_t tmp;
    int     sel, a, ax;
    sel = $urandom_range(0, 99);
    b.box_valid = ($urandom_range(0, 3) != 0);
    b.restart   = ($urandom_range(0, 7) == 0);
    if (sel >= 85) begin
      for (a = 0; a < AXES; a++) begin
        b.lo[a] = $urandom;
        b.hi[a] = $urandom;
      end
      b.box_valid = 1'($urandom_range(0, 1));
      b.restart   = 1'($urandom_range(0, 1));
    end else begin
      t = longint'($urandom_range(0, 48 * ONE));
      if ($urandom_range(0, 9) == 0) t = -t;
      for (a = 0; a < AXES; a++) begin
        o = longint'($signed(ray_org[a]));
        d = longint'($signed(ray_dir[a]));
        c = (sel >= 60 && sel < 72) ? o : o + scale_t(d, t);
        m_lo = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 4 * ONE));
        m_hi = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 4 * ONE));
        b.lo[a] = to_coord(c - m_lo);
        b.hi[a] = to_coord(c + m_hi);
      end
      if (sel >= 72) begin
        ax = $urandom_range(0, AXES - 1);
        tmp = b.lo[ax];
        b.lo[ax] = b.hi[ax];
        b.hi[ax] = tmp;
      end
    end
    return b;
  endfunction

  // Ray for one phase: the extremes first, then random settings
  task automatic choose_ray(int ph, output vec3_t org, output vec3_t dir);
    int a;
    for (a = 0; a < AXES; a++) begin
      unique case (ph)
        0: begin
          org[a] = '0;
          dir[a] = '0;
        end
        1: begin
          org[a] = CMAX;
          dir[a] = CMIN;
        end
        2: begin
          org[a] = CMIN;
          dir[a] = CMAX;
        end
        3: begin
          org[a] = rand_coord(64);
          dir[a] = (a == 0) ? coord_t'(1) : (a == 1) ? '1 : '0;
        end
        default: begin
          if (ph % 5 == 4) begin
            org[a] = $urandom;
            dir[a] = $urandom;
          end else begin
            org[a] = rand_coord(64);
            dir[a] = ($urandom_range(0, 4) == 0) ? '0 : rand_coord(4);
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access until pready
  // --------------------------------------------------------------------------
  task automatic apb_write(int idx, coord_t val);
    int addr;
    addr = idx * 4;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr[AW-1:0];
    pwdata  <= DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  // Wait for the block to drain, then load a new ray
  task automatic load_ray(vec3_t org, vec3_t dir);
    int a;
    while (hits_due.size() != 0) @(posedge clk);
    for (a = 0; a < AXES; a++) apb_write(rbnh_pkg::REG_ORIGIN_X + a, org[a]);
    for (a = 0; a < AXES; a++) apb_write(rbnh_pkg::REG_DIRECTION_X + a, dir[a]);
    psel    <= 1'b0;
    penable <= 1'b0;
    ray_org = org;
    ray_dir = dir;
  endtask

  // Offer one box request and queue its expected result once taken
  task automatic send_box(box_t b, logic typed, result_t want);
    int      gap;
    result_t r;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IW'({b.hi, b.lo});
    s_tuser  <= {b.restart, b.box_valid};
    do @(posedge clk); while (s_tready !== 1'b1);
    r = track_nearest_hit(b);
    hits_due.push_back(typed ? want : r);
  endtask

  task automatic check_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("ERROR result %0d %s: expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    vec3_t   org, dir;
    result_t none;
    int      i, ph;
    none = '0;

    // Ray along +x, still in y, along -z from the origin
    dir_tab[0]  = dir_row(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE,
                          1'b1, 1'b0, 1'b1, 1'b0, CMAX);
    dir_tab[1]  = dir_row(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                          1'b1, 1'b0, 1'b1, 1'b1, 0);
    dir_tab[2]  = dir_row(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                          1'b1, 1'b0, 1'b1, 1'b1, 0);
    dir_tab[3]  = dir_row(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                          1'b0, 1'b0, 1'b1, 1'b0, 0);
    dir_tab[4]  = dir_row(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE,
                          1'b1, 1'b1, 1'b1, 1'b0, CMAX);
    dir_tab[5]  = dir_row(2*ONE, -ONE, -4*ONE, 3*ONE, ONE, -2*ONE,
                          1'b0, 1'b0, 1'b0, 1'b0, 0);
    dir_tab[6]  = dir_row(5*ONE, -ONE, -12*ONE, 6*ONE, ONE, -10*ONE,
                          1'b0, 1'b0, 1'b0, 1'b0, 0);
    dir_tab[7]  = dir_row(ONE, -ONE, -4*ONE, 3*ONE, ONE, -ONE,
                          1'b0, 1'b0, 1'b0, 1'b0, 0);
    dir_tab[8]  = dir_row(-3*ONE, -ONE, 2*ONE, -2*ONE, ONE, 6*ONE,
                          1'b1, 1'b0, 1'b0, 1'b0, 0);
    dir_tab[9]  = dir_row(3*ONE, ONE, -ONE, ONE, -ONE, -4*ONE,
                          1'b1, 1'b0, 1'b0, 1'b0, 0);
    dir_tab[10] = dir_row(3*ONE, -ONE, -4*ONE, ONE, ONE, -ONE,
                          1'b1, 1'b1, 1'b0, 1'b0, 0);
    dir_tab[11] = dir_row(0, -ONE, -ONE, ONE, ONE, ONE,
                          1'b1, 1'b0, 1'b1, 1'b1, 0);
    dir_tab[12] = dir_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                          1'b1, 1'b0, 1'b1, 1'b1, 0);
    dir_tab[13] = dir_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                          1'b0, 1'b1, 1'b1, 1'b0, CMAX);
    dir_tab[14] = dir_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                          1'b1, 1'b0, 1'b1, 1'b0, CMAX);
    dir_tab[15] = dir_row(2*ONE, 0, -4*ONE, 2*ONE, 0, -4*ONE,
                          1'b0, 1'b0, 1'b0, 1'b0, 0);

    // Hold reset, then release
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    org = '0;
    dir = {coord_t'(-2 * ONE), coord_t'(0), coord_t'(ONE)};
    load_ray(org, dir);
    for (i = 0; i < N_DIRECTED; i++)
      send_box(dir_tab[i].box, dir_tab[i].typed, dir_tab[i].want);
    s_tvalid <= 1'b0;

    // Random boxes, one ray setting per phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      choose_ray(ph, org, dir);
      load_ray(org, dir);
      for (i = 0; i < PHASE_BOXES; i++) send_box(make_box(), 1'b0, none);
      s_tvalid <= 1'b0;
    end

    // Drain, then allow time for any stray result
    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall at random, compare each taken result
  // --------------------------------------------------------------------------
  initial begin : result_check
    result_t got, want;
    int      stall, a;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got = {m_tuser[0], m_tdata[4*CW-1:0]};
      if (hits_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR unexpected result: hit %b distance %h", got.hit, got.distance);
      end else begin
        want = hits_due.pop_front();
        check_field("hit", coord_t'(want.hit), coord_t'(got.hit));
        check_field("nearest_distance", want.distance, got.distance);
        for (a = 0; a < AXES; a++)
          check_field($sformatf("hit_point[%0d]", a), want.point[a], got.point[a]);
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
